### rtl/core/afc_pkg.sv
// ----------------------------------------------------------------------------
// afc_pkg
// Shared constants and types for the box/frustum cull test unit.
// ----------------------------------------------------------------------------
package afc_pkg;

    localparam int NUM_PLANES = 6;
    localparam int FRAC_BITS  = 16;

    localparam int COORD_W = 32;                       // field width
    localparam int EXT_W   = COORD_W + 1;              // far corner, exact
    localparam int PROD_W  = COORD_W + EXT_W;          // coef * corner
    localparam int ACC_W   = PROD_W + 2;               // three products plus offset
    localparam int IDX_W   = 3;                        // plane_index field width
    localparam int PLANE_W = (NUM_PLANES > 1) ? $clog2(NUM_PLANES) : 1;

    localparam logic OP_LOAD = 1'b0;
    localparam logic OP_TEST = 1'b1;

    typedef struct packed {
        logic signed [COORD_W-1:0] nx;
        logic signed [COORD_W-1:0] ny;
        logic signed [COORD_W-1:0] nz;
        logic signed [COORD_W-1:0] d;
    } plane_t;

    typedef struct packed {
        logic acc_load;   // acc <= offset scaled to product precision
        logic acc_add;    // acc <= acc + product
        logic mul_en;     // product <= coef * corner
    } mac_ctrl_t;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_PREP = 4'b0010,
        S_RUN  = 4'b0100,
        S_DONE = 4'b1000
    } state_t;

endpackage

### rtl/core/afc_item_if.sv
// ----------------------------------------------------------------------------
// afc_item_if
// Input channel: plane loads and box tests.
// ----------------------------------------------------------------------------
interface afc_item_if;
    import afc_pkg::*;

    logic                      valid;
    logic                      ready;
    logic                      operation;
    logic [IDX_W-1:0]          plane_index;
    logic signed [COORD_W-1:0] normal_x;
    logic signed [COORD_W-1:0] normal_y;
    logic signed [COORD_W-1:0] normal_z;
    logic signed [COORD_W-1:0] plane_offset;
    logic signed [COORD_W-1:0] box_x;
    logic signed [COORD_W-1:0] box_y;
    logic signed [COORD_W-1:0] box_z;
    logic signed [COORD_W-1:0] size_x;
    logic signed [COORD_W-1:0] size_y;
    logic signed [COORD_W-1:0] size_z;

    modport source (
        output valid, operation, plane_index, normal_x, normal_y, normal_z,
               plane_offset, box_x, box_y, box_z, size_x, size_y, size_z,
        input  ready
    );

    modport sink (
        input  valid, operation, plane_index, normal_x, normal_y, normal_z,
               plane_offset, box_x, box_y, box_z, size_x, size_y, size_z,
        output ready
    );

endinterface

### rtl/core/afc_result_if.sv
// ----------------------------------------------------------------------------
// afc_result_if
// Output channel: one visibility flag per box test.
// ----------------------------------------------------------------------------
interface afc_result_if;

    logic valid;
    logic ready;
    logic visible;

    modport source (
        output valid, visible,
        input  ready
    );

    modport sink (
        input  valid, visible,
        output ready
    );

endinterface

### rtl/core/afc_plane_store.sv
// ----------------------------------------------------------------------------
// afc_plane_store
// Clip plane register file: one write port, one read port, cleared at reset.
// ----------------------------------------------------------------------------
module afc_plane_store (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           we,
    input  logic [afc_pkg::IDX_W-1:0]      wr_index,
    input  afc_pkg::plane_t                wr_plane,
    input  logic [afc_pkg::PLANE_W-1:0]    rd_index,
    output afc_pkg::plane_t                rd_plane
);
    import afc_pkg::*;

    plane_t plane_reg [NUM_PLANES];
    logic   in_range;

    // Drop loads aimed past the last slot
    assign in_range = ({1'b0, wr_index} < (IDX_W + 1)'(NUM_PLANES));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < NUM_PLANES; i++)
            begin
                plane_reg[i] <= '0;
            end
        end
        else if (we && in_range)
        begin
            plane_reg[wr_index[PLANE_W-1:0]] <= wr_plane;
        end
    end

    assign rd_plane = plane_reg[rd_index];

endmodule

### rtl/core/afc_mac.sv
// ----------------------------------------------------------------------------
// afc_mac
// Shared multiply-accumulate: one exact 32x33 product per cycle while mul_en
// is set, into a 67-bit accumulator, with the sign of the finished sum.
// ----------------------------------------------------------------------------
module afc_mac (
    input  logic                                clk,
    input  logic                                rst_n,
    input  afc_pkg::mac_ctrl_t                  ctrl,
    input  logic signed [afc_pkg::COORD_W-1:0]  coef,
    input  logic signed [afc_pkg::EXT_W-1:0]    corner,
    input  logic signed [afc_pkg::COORD_W-1:0]  offset,
    output logic                                negative
);
    import afc_pkg::*;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [ACC_W-1:0]  acc_reg;
    logic signed [ACC_W-1:0]  sum;
    logic signed [ACC_W-1:0]  offset_scaled;

    assign offset_scaled = {{(ACC_W - COORD_W - FRAC_BITS){offset[COORD_W-1]}},
                            offset, {FRAC_BITS{1'b0}}};
    assign sum           = acc_reg + ACC_W'(prod_reg);
    assign negative      = sum[ACC_W-1];

    always_ff @(posedge clk)
    begin
        if (ctrl.mul_en)
        begin
            prod_reg <= PROD_W'(coef) * PROD_W'(corner);
        end
        if (ctrl.acc_load)
        begin
            acc_reg <= offset_scaled;
        end
        else if (ctrl.acc_add)
        begin
            acc_reg <= sum;
        end
    end

    mac_exclusive_a: assert property (@(posedge clk) disable iff (!rst_n)
        !(ctrl.acc_load && ctrl.acc_add))
        else $error("accumulator load and add in the same cycle");

    // An add always consumes a product formed the cycle before
    mac_add_after_mul_a: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.acc_add |-> $past(ctrl.mul_en))
        else $error("accumulator add without a fresh product");

    mac_load_with_mul_a: assert property (@(posedge clk) disable iff (!rst_n)
        ctrl.acc_load |-> ctrl.mul_en)
        else $error("plane start without first product");

endmodule

### rtl/core/aabb_frustum_cull_test_unit.sv
// ----------------------------------------------------------------------------
// aabb_frustum_cull_test_unit
// Tests an axis-aligned box against all six stored clip planes.
//
//   channel  dir  transaction
//   item     in   load one plane (operation 0) or test one box (operation 1)
//   result   out  visible flag, one per box test, none per load
//
// A load leaves the unit idle; the next item can be accepted the cycle after.
// A box test runs a prep step, then per plane 3 products and a sign check on
// the one shared 32x33 multiplier, then a done state that posts the result.
// Per plane only the corner maximizing the plane value is evaluated: the box
// is outside a plane exactly when that corner is.
// Reset clears the plane store to zero. A stalled result holds the unit in
// its final state; the next item is taken once the result is posted.
// ----------------------------------------------------------------------------
module aabb_frustum_cull_test_unit (
    input  logic          clk,
    input  logic          rst_n,
    afc_item_if.sink      item,
    afc_result_if.source  result
);
    import afc_pkg::*;

    state_t state_reg, state_next;
    logic [PLANE_W-1:0] plane_reg, plane_next;
    logic [1:0]         step_reg, step_next;
    logic               culled_reg, culled_next;
    logic               result_valid_reg, result_valid_next;
    logic               visible_reg, visible_next;

    logic signed [EXT_W-1:0] lo_reg [3];
    logic signed [EXT_W-1:0] hi_reg [3];
    logic signed [EXT_W-1:0] max_reg [3];
    logic signed [EXT_W-1:0] min_reg [3];

    logic                    accept;
    logic                    store_we;
    plane_t                  wr_plane;
    plane_t                  cur_plane;
    mac_ctrl_t               mac_ctrl;
    logic signed [COORD_W-1:0] coef;
    logic signed [EXT_W-1:0]   corner;
    logic                    corner_negative;
    logic [1:0]              axis;

    assign item.ready     = (state_reg == S_IDLE);
    assign accept         = item.valid && item.ready;
    assign store_we       = accept && (item.operation == OP_LOAD);
    assign result.valid   = result_valid_reg;
    assign result.visible = visible_reg;

    assign wr_plane.nx = item.normal_x;
    assign wr_plane.ny = item.normal_y;
    assign wr_plane.nz = item.normal_z;
    assign wr_plane.d  = item.plane_offset;

    afc_plane_store u_store (
        .clk      (clk),
        .rst_n    (rst_n),
        .we       (store_we),
        .wr_index (item.plane_index),
        .wr_plane (wr_plane),
        .rd_index (plane_reg),
        .rd_plane (cur_plane)
    );

    // Pick the coefficient for this step and the corner that maximizes it
    always_comb
    begin
        case (step_reg)
            2'd0:    begin coef = cur_plane.nx; axis = 2'd0; end
            2'd1:    begin coef = cur_plane.ny; axis = 2'd1; end
            default: begin coef = cur_plane.nz; axis = 2'd2; end
        endcase
        corner = coef[COORD_W-1] ? min_reg[axis] : max_reg[axis];
    end

    always_comb
    begin
        mac_ctrl          = '0;
        if (state_reg == S_RUN)
        begin
            mac_ctrl.mul_en   = (step_reg != 2'd3);
            mac_ctrl.acc_load = (step_reg == 2'd0);
            mac_ctrl.acc_add  = (step_reg == 2'd1) || (step_reg == 2'd2);
        end
    end

    afc_mac u_mac (
        .clk      (clk),
        .rst_n    (rst_n),
        .ctrl     (mac_ctrl),
        .coef     (coef),
        .corner   (corner),
        .offset   (cur_plane.d),
        .negative (corner_negative)
    );

    always_comb
    begin
        state_next        = state_reg;
        plane_next        = plane_reg;
        step_next         = step_reg;
        culled_next       = culled_reg;
        result_valid_next = result_valid_reg;
        visible_next      = visible_reg;

        if (result_valid_reg && result.ready)
        begin
            result_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (accept && (item.operation == OP_TEST))
                begin
                    state_next  = S_PREP;
                    culled_next = 1'b0;
                    plane_next  = '0;
                    step_next   = '0;
                end
            end
            S_PREP:
            begin
                state_next = S_RUN;
            end
            S_RUN:
            begin
                step_next = step_reg + 2'd1;
                if (step_reg == 2'd3)
                begin
                    if (corner_negative)
                    begin
                        culled_next = 1'b1;
                    end
                    if (plane_reg == PLANE_W'(NUM_PLANES - 1))
                    begin
                        plane_next = '0;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        plane_next = plane_reg + 1'b1;
                    end
                end
            end
            S_DONE:
            begin
                // Hold until the output register is free
                if (!result_valid_reg || result.ready)
                begin
                    result_valid_next = 1'b1;
                    visible_next      = !culled_reg;
                    state_next        = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            plane_reg        <= '0;
            step_reg         <= '0;
            culled_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            plane_reg        <= plane_next;
            step_reg         <= step_next;
            culled_reg       <= culled_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        visible_reg <= visible_next;
        if (accept)
        begin
            lo_reg[0] <= EXT_W'(item.box_x);
            lo_reg[1] <= EXT_W'(item.box_y);
            lo_reg[2] <= EXT_W'(item.box_z);
            hi_reg[0] <= EXT_W'(item.box_x) + EXT_W'(item.size_x);
            hi_reg[1] <= EXT_W'(item.box_y) + EXT_W'(item.size_y);
            hi_reg[2] <= EXT_W'(item.box_z) + EXT_W'(item.size_z);
        end
        if (state_reg == S_PREP)
        begin
            for (int k = 0; k < 3; k++)
            begin
                if (hi_reg[k] > lo_reg[k])
                begin
                    max_reg[k] <= hi_reg[k];
                    min_reg[k] <= lo_reg[k];
                end
                else
                begin
                    max_reg[k] <= lo_reg[k];
                    min_reg[k] <= hi_reg[k];
                end
            end
        end
    end

    test_starts_prep_a: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && (item.operation == OP_TEST)) |=> (state_reg == S_PREP))
        else $error("accepted box test did not start");

    run_ends_clean_a: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_DONE) |-> (step_reg == 2'd0) && (plane_reg == '0))
        else $error("plane sweep left counters mid-way");

    result_from_done_a: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == S_DONE))
        else $error("result posted outside the final state");

    no_load_while_busy_a: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> !store_we)
        else $error("plane store written during a box test");

endmodule
